// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the editor buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FLE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define FLE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/fle_pkg.sv =====
// Types, constants and helpers for the fixed line text editor buffer.
package fle_pkg;

	localparam int LINES      = 16;
	localparam int LINE_CHARS = 32;
	localparam int DEPTH      = LINES * LINE_CHARS;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int NUM_W      = ADDR_W + 1;
	localparam int CH_W       = 7;
	localparam int NPHASE     = 4;

	localparam logic [CH_W-1:0] CH_BS    = 7'h08;
	localparam logic [CH_W-1:0] CH_LF    = 7'h0A;
	localparam logic [CH_W-1:0] CH_DEL   = 7'h7F;
	localparam logic [CH_W-1:0] CH_SP    = 7'h20;
	localparam logic [CH_W-1:0] CH_TILDE = 7'h7E;

	typedef enum logic [3:0] {
		ACT_WRITE = 4'd0,
		ACT_LEFT  = 4'd1,
		ACT_RIGHT = 4'd2,
		ACT_UP    = 4'd3,
		ACT_DOWN  = 4'd4,
		ACT_CLRLN = 4'd5,
		ACT_CLRALL = 4'd6,
		ACT_HEAD  = 4'd7,
		ACT_END   = 4'd8,
		ACT_SAVED = 4'd9,
		ACT_READ  = 4'd10
	} act_t;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] byte_in;
		logic [3:0] read_line;
		logic [4:0] read_column;
	} in_beat_t;

	typedef struct packed {
		logic       changed;
		logic [3:0] cursor_line_out;
		logic [5:0] cursor_column_out;
		logic [4:0] line_count_out;
		logic       dirty_out;
		logic [6:0] read_char;
		logic [5:0] read_length;
	} out_beat_t;

	typedef enum logic [1:0] {
		PK_NONE = 2'd0,
		PK_COPY = 2'd1,
		PK_FILL = 2'd2,
		PK_READ = 2'd3
	} phase_kind_t;

	typedef struct packed {
		phase_kind_t       kind;
		logic              down;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [NUM_W-1:0]  cnt;
		logic [CH_W-1:0]   data;
	} phase_t;

	typedef struct packed {
		logic              start;
		phase_t [NPHASE-1:0] ph;
	} mov_cmd_t;

	typedef struct packed {
		logic            done;
		logic [CH_W-1:0] rdata;
	} mov_sts_t;

	function automatic logic [NUM_W-1:0] addr_of(input logic [4:0] line, input logic [5:0] col);
		addr_of = NUM_W'(line) * NUM_W'(LINE_CHARS) + NUM_W'(col);
	endfunction

	function automatic phase_t mk_phase(input phase_kind_t kind, input logic down,
			input logic [NUM_W-1:0] src, input logic [NUM_W-1:0] dst,
			input logic [NUM_W-1:0] cnt, input logic [CH_W-1:0] data);
		phase_t p;
		p.kind = kind;
		p.down = down;
		p.src  = src[ADDR_W-1:0];
		p.dst  = dst[ADDR_W-1:0];
		p.cnt  = cnt;
		p.data = data;
		mk_phase = p;
	endfunction

endpackage

// ===== hdl/fle_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module fle_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 7,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== hdl/fle_mover.sv =====
// Text store with a sequencer that runs copy, fill and read phases over it.
module fle_mover (
	input  logic             clk,
	input  logic             arst_n,
	input  fle_pkg::mov_cmd_t cmd,
	output fle_pkg::mov_sts_t sts
);
	import fle_pkg::*;

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_NEXT = 5'b00010,
		M_RD   = 5'b00100,
		M_WR   = 5'b01000,
		M_FILL = 5'b10000
	} mst_t;

	mst_t              st_q;
	logic [2:0]        k_q;
	phase_kind_t       kind_q;
	logic              down_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] dst_q;
	logic [NUM_W-1:0]  cnt_q;
	logic [CH_W-1:0]   data_q;
	logic              done_q;
	phase_t            nph;

	logic              ram_we;
	logic              ram_re;
	logic [CH_W-1:0]   ram_wdata;
	logic [CH_W-1:0]   ram_rdata;

	assign nph       = cmd.ph[k_q[1:0]];
	assign ram_re    = (st_q == M_RD);
	assign ram_we    = (st_q == M_WR) || (st_q == M_FILL);
	assign ram_wdata = (st_q == M_WR) ? ram_rdata : data_q;

	fle_ram #(.DEPTH(DEPTH), .WIDTH(CH_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dst_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (src_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			k_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				M_IDLE: begin
					if (cmd.start) begin
						k_q  <= '0;
						st_q <= M_NEXT;
					end
				end
				M_NEXT: begin
					if (k_q == 3'(NPHASE)) begin
						done_q <= 1'b1;
						st_q   <= M_IDLE;
					end else if (nph.kind == PK_NONE || nph.cnt == '0) begin
						k_q <= k_q + 3'd1;
					end else if (nph.kind == PK_FILL) begin
						st_q <= M_FILL;
					end else begin
						st_q <= M_RD;
					end
				end
				M_RD: begin
					if (kind_q == PK_READ) begin
						k_q  <= k_q + 3'd1;
						st_q <= M_NEXT;
					end else begin
						st_q <= M_WR;
					end
				end
				M_WR, M_FILL: begin
					if (cnt_q == NUM_W'(1)) begin
						k_q  <= k_q + 3'd1;
						st_q <= M_NEXT;
					end else begin
						st_q <= (st_q == M_WR) ? M_RD : M_FILL;
					end
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	// Load a phase on entry, advance both pointers after each write.
	always_ff @(posedge clk) begin
		if (st_q == M_NEXT) begin
			kind_q <= nph.kind;
			down_q <= nph.down;
			src_q  <= nph.src;
			dst_q  <= nph.dst;
			cnt_q  <= nph.cnt;
			data_q <= nph.data;
		end else if (ram_we) begin
			cnt_q <= cnt_q - NUM_W'(1);
			src_q <= down_q ? src_q - ADDR_W'(1) : src_q + ADDR_W'(1);
			dst_q <= down_q ? dst_q - ADDR_W'(1) : dst_q + ADDR_W'(1);
		end
	end

	assign sts.done  = done_q;
	assign sts.rdata = ram_rdata;
endmodule

// ===== hdl/fixed_line_text_editor_buffer.sv =====
// Each command runs through the states S_IDLE, S_LEN0, S_LEN1, S_EXEC, S_RUN and S_PUT;
// the mover run in S_RUN grows with each copied and filled character and with a read, and
// is longest for a line split near the top of an almost full buffer.
// Throughput: one command at a time; in_stall stays high until the result beat is loaded.
// Reset: asynchronous; afterwards a clearing pass writes 512 spaces while in_stall stays
// high. The insert flag resets to 0.
module fixed_line_text_editor_buffer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fle_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fle_pkg::out_beat_t  out_data,
	input  logic                wr_en,
	input  logic                wr_data
);
	import fle_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [7:0] {
		S_INIT  = 8'b00000001,
		S_INITW = 8'b00000010,
		S_IDLE  = 8'b00000100,
		S_LEN0  = 8'b00001000,
		S_LEN1  = 8'b00010000,
		S_EXEC  = 8'b00100000,
		S_RUN   = 8'b01000000,
		S_PUT   = 8'b10000000
	} st_t;

	st_t                 state_q;
	in_beat_t            req_q;
	logic [3:0]          cur_q;
	logic [5:0]          col_q;
	logic [4:0]          lc_q;
	logic                dirty_q;
	logic                ins_q;
	logic [5:0]          len_q [LINES];
	logic [3:0]          len_idx_q;
	logic [5:0]          cl_q;
	logic [5:0]          ol_q;
	logic                chg_q;
	logic [5:0]          rlen_q;
	logic                start_q;
	phase_t [NPHASE-1:0] ph_q;
	logic                out_valid_q;
	out_beat_t           out_q;

	mov_cmd_t            cmd;
	mov_sts_t            sts;
	logic [5:0]          len_rd;
	logic [3:0]          oth_idx;

	logic [3:0]          n_cur;
	logic [5:0]          n_col;
	logic [4:0]          n_lc;
	logic                n_dirty;
	logic                n_chg;
	logic [5:0]          n_rlen;
	logic [5:0]          n_len [LINES];
	phase_t [NPHASE-1:0] n_ph;
	logic                put_ok;

	assign cmd.start = start_q;
	assign cmd.ph    = ph_q;

	fle_mover u_mover (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	assign len_rd    = len_q[len_idx_q];
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign put_ok    = !out_valid_q || !out_stall;

	// Second length lookup depends on the command.
	always_comb begin
		oth_idx = cur_q;
		case (req_q.action)
			ACT_WRITE, ACT_UP: oth_idx = cur_q - 4'd1;
			ACT_DOWN:          oth_idx = cur_q + 4'd1;
			ACT_END:           oth_idx = 4'(lc_q - 5'd1);
			ACT_CLRALL:        oth_idx = '0;
			ACT_READ:          oth_idx = req_q.read_line;
			default:           oth_idx = cur_q;
		endcase
	end

	always_comb begin
		logic [NUM_W-1:0] base;
		logic [NUM_W-1:0] nbase;
		logic [6:0]       jsum;
		logic [5:0]       tail;
		logic [CH_W-1:0]  ch;
		logic [4:0]       cur5;

		cur5   = {1'b0, cur_q};
		ch     = req_q.byte_in[CH_W-1:0];
		base   = addr_of(cur5, 6'd0);
		nbase  = addr_of(cur5 + 5'd1, 6'd0);
		jsum   = {1'b0, ol_q} + {1'b0, cl_q};
		tail   = cl_q - col_q;
		n_cur   = cur_q;
		n_col   = col_q;
		n_lc    = lc_q;
		n_dirty = dirty_q;
		n_chg   = 1'b0;
		n_rlen  = '0;
		n_len   = len_q;
		for (int k = 0; k < NPHASE; k++)
			n_ph[k] = mk_phase(PK_NONE, 1'b0, '0, '0, '0, '0);

		case (req_q.action)
			ACT_WRITE: begin
				if (ch == CH_BS) begin
					if (col_q == '0) begin
						if (cur_q != '0 && jsum <= 7'(LINE_CHARS)) begin
							// join onto the previous line, pull later lines up
							for (int i = 0; i < LINES; i++) begin
								if (5'(i) + 5'd1 == cur5)
									n_len[i] = 6'(jsum);
								else if (5'(i) >= cur5 && 5'(i) + 5'd1 < lc_q)
									n_len[i] = len_q[(i + 1) % LINES];
								else if (5'(i) + 5'd1 == lc_q)
									n_len[i] = '0;
							end
							n_ph[0] = mk_phase(PK_COPY, 1'b0, base,
								addr_of(cur5 - 5'd1, ol_q), NUM_W'(cl_q), CH_SP);
							n_ph[1] = mk_phase(PK_COPY, 1'b0, nbase, base,
								addr_of(lc_q - 5'd1 - cur5, 6'd0), CH_SP);
							n_ph[2] = mk_phase(PK_FILL, 1'b0, '0,
								addr_of(lc_q - 5'd1, 6'd0), NUM_W'(LINE_CHARS), CH_SP);
							n_lc    = lc_q - 5'd1;
							n_cur   = cur_q - 4'd1;
							n_col   = ol_q;
							n_chg   = 1'b1;
							n_dirty = 1'b1;
						end
					end else begin
						n_len[cur_q] = cl_q - 6'd1;
						n_ph[0] = mk_phase(PK_COPY, 1'b0, base + NUM_W'(col_q),
							base + NUM_W'(col_q) - NUM_W'(1), NUM_W'(tail), CH_SP);
						n_ph[1] = mk_phase(PK_FILL, 1'b0, '0,
							base + NUM_W'(cl_q) - NUM_W'(1), NUM_W'(1), CH_SP);
						n_col   = col_q - 6'd1;
						n_chg   = 1'b1;
						n_dirty = 1'b1;
					end
				end else if (ch == CH_LF) begin
					if (lc_q < 5'(LINES)) begin
						// push later lines down, then move the tail to the new line
						n_len[cur_q] = col_q;
						for (int i = 0; i < LINES; i++) begin
							if (5'(i) == cur5 + 5'd1)
								n_len[i] = tail;
							else if (5'(i) > cur5 + 5'd1 && 5'(i) <= lc_q)
								n_len[i] = len_q[(i + LINES - 1) % LINES];
						end
						n_ph[0] = mk_phase(PK_COPY, 1'b1, addr_of(lc_q, 6'd0) - NUM_W'(1),
							addr_of(lc_q, 6'(LINE_CHARS - 1)),
							addr_of(lc_q - 5'd1 - cur5, 6'd0), CH_SP);
						n_ph[1] = mk_phase(PK_FILL, 1'b0, '0, nbase,
							NUM_W'(LINE_CHARS), CH_SP);
						n_ph[2] = mk_phase(PK_COPY, 1'b0, base + NUM_W'(col_q), nbase,
							NUM_W'(tail), CH_SP);
						n_ph[3] = mk_phase(PK_FILL, 1'b0, '0, base + NUM_W'(col_q),
							NUM_W'(tail), CH_SP);
						n_lc    = lc_q + 5'd1;
						n_cur   = cur_q + 4'd1;
						n_col   = '0;
						n_chg   = 1'b1;
						n_dirty = 1'b1;
					end
				end else if (ch == CH_DEL) begin
					if (col_q < cl_q) begin
						n_len[cur_q] = cl_q - 6'd1;
						n_ph[0] = mk_phase(PK_COPY, 1'b0, base + NUM_W'(col_q) + NUM_W'(1),
							base + NUM_W'(col_q), NUM_W'(tail - 6'd1), CH_SP);
						n_ph[1] = mk_phase(PK_FILL, 1'b0, '0,
							base + NUM_W'(cl_q) - NUM_W'(1), NUM_W'(1), CH_SP);
						n_chg   = 1'b1;
						n_dirty = 1'b1;
					end
				end else if (ch >= CH_SP && ch <= CH_TILDE) begin
					if (ins_q) begin
						if (cl_q < 6'(LINE_CHARS)) begin
							n_len[cur_q] = cl_q + 6'd1;
							n_ph[0] = mk_phase(PK_COPY, 1'b1,
								base + NUM_W'(cl_q) - NUM_W'(1), base + NUM_W'(cl_q),
								NUM_W'(tail), CH_SP);
							n_ph[1] = mk_phase(PK_FILL, 1'b0, '0, base + NUM_W'(col_q),
								NUM_W'(1), ch);
							n_col   = col_q + 6'd1;
							n_chg   = 1'b1;
							n_dirty = 1'b1;
						end
					end else if (col_q < 6'(LINE_CHARS)) begin
						if (col_q >= cl_q)
							n_len[cur_q] = col_q + 6'd1;
						n_ph[0] = mk_phase(PK_FILL, 1'b0, '0, base + NUM_W'(col_q),
							NUM_W'(1), ch);
						n_col   = col_q + 6'd1;
						n_chg   = 1'b1;
						n_dirty = 1'b1;
					end
				end
			end
			ACT_LEFT: begin
				if (col_q != '0) begin
					n_col = col_q - 6'd1;
					n_chg = 1'b1;
				end
			end
			ACT_RIGHT: begin
				if (col_q < cl_q) begin
					n_col = col_q + 6'd1;
					n_chg = 1'b1;
				end
			end
			ACT_UP: begin
				if (cur_q != '0) begin
					n_cur = cur_q - 4'd1;
					if (col_q > ol_q)
						n_col = ol_q;
					n_chg = 1'b1;
				end
			end
			ACT_DOWN: begin
				if (cur5 + 5'd1 < lc_q) begin
					n_cur = cur_q + 4'd1;
					if (col_q > ol_q)
						n_col = ol_q;
					n_chg = 1'b1;
				end
			end
			ACT_CLRLN: begin
				n_chg        = (cl_q != '0);
				n_len[cur_q] = '0;
				n_col        = '0;
				if (cl_q != '0)
					n_dirty = 1'b1;
				n_ph[0] = mk_phase(PK_FILL, 1'b0, '0, base, NUM_W'(LINE_CHARS), CH_SP);
			end
			ACT_CLRALL: begin
				n_chg = (lc_q != 5'd1) || (ol_q != '0);
				if (n_chg)
					n_dirty = 1'b1;
				for (int i = 0; i < LINES; i++)
					n_len[i] = '0;
				n_cur = '0;
				n_col = '0;
				n_lc  = 5'd1;
				n_ph[0] = mk_phase(PK_FILL, 1'b0, '0, '0, NUM_W'(DEPTH), CH_SP);
			end
			ACT_HEAD: begin
				n_chg = (cur_q != '0) || (col_q != '0);
				n_cur = '0;
				n_col = '0;
			end
			ACT_END: begin
				n_chg = (cur5 != lc_q - 5'd1) || (col_q != ol_q);
				n_cur = 4'(lc_q - 5'd1);
				n_col = ol_q;
			end
			ACT_SAVED: n_dirty = 1'b0;
			ACT_READ: begin
				n_rlen  = ol_q;
				n_ph[0] = mk_phase(PK_READ, 1'b0,
					addr_of({1'b0, req_q.read_line}, {1'b0, req_q.read_column}),
					'0, NUM_W'(1), CH_SP);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cur_q       <= '0;
			col_q       <= '0;
			lc_q        <= 5'd1;
			dirty_q     <= 1'b0;
			ins_q       <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LINES; i++)
				len_q[i] <= '0;
		end else begin
			start_q <= 1'b0;
			if (wr_en)
				ins_q <= wr_data;
			if (out_valid_q && !out_stall && state_q != S_PUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					start_q <= 1'b1;
					state_q <= S_INITW;
				end
				S_INITW: begin
					if (sts.done)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid)
						state_q <= S_LEN0;
				end
				S_LEN0: state_q <= S_LEN1;
				S_LEN1: state_q <= S_EXEC;
				S_EXEC: begin
					cur_q   <= n_cur;
					col_q   <= n_col;
					lc_q    <= n_lc;
					dirty_q <= n_dirty;
					len_q   <= n_len;
					start_q <= 1'b1;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (sts.done)
						state_q <= S_PUT;
				end
				S_PUT: begin
					if (put_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Beat capture, length lookups, phase list and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT: begin
				ph_q[0] <= mk_phase(PK_FILL, 1'b0, '0, '0, NUM_W'(DEPTH), CH_SP);
				for (int k = 1; k < NPHASE; k++)
					ph_q[k] <= mk_phase(PK_NONE, 1'b0, '0, '0, '0, '0);
			end
			S_IDLE: begin
				if (in_valid) begin
					req_q     <= in_data;
					len_idx_q <= cur_q;
				end
			end
			S_LEN0: begin
				cl_q      <= len_rd;
				len_idx_q <= oth_idx;
			end
			S_LEN1: ol_q <= len_rd;
			S_EXEC: begin
				ph_q   <= n_ph;
				chg_q  <= n_chg;
				rlen_q <= n_rlen;
			end
			S_PUT: begin
				if (put_ok) begin
					out_q.changed           <= chg_q;
					out_q.cursor_line_out   <= cur_q;
					out_q.cursor_column_out <= col_q;
					out_q.line_count_out    <= lc_q;
					out_q.dirty_out         <= dirty_q;
					out_q.read_char         <= (req_q.action == ACT_READ) ? sts.rdata : '0;
					out_q.read_length       <= rlen_q;
				end
			end
			default: ;
		endcase
	end

	`FLE_ASSERT(a_lc_range, (lc_q != 5'd0) && (lc_q <= 5'(LINES)), "line count out of range")
	`FLE_ASSERT(a_cur_in_doc, 5'(cur_q) < lc_q, "cursor line beyond line count")
	`FLE_ASSERT(a_done_wait, !sts.done || state_q == S_RUN || state_q == S_INITW, "stray mover done")
	`FLE_ASSERT_NEXT(a_start_run, start_q && state_q == S_RUN, !sts.done, "mover finished too early")
endmodule

// ===== verif/fixed_line_text_editor_buffer_tb.sv =====
// Self-checking testbench for the fixed line text editor buffer.
`timescale 1ns / 1ps

module fixed_line_text_editor_buffer_tb;
	import fle_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;
	logic      wr_en;
	logic      wr_data;

	fixed_line_text_editor_buffer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.wr_en(wr_en), .wr_data(wr_data)
	);

	// editor state as predicted
	logic [6:0] grid [LINES][LINE_CHARS];
	int         len_of [LINES];
	int         cur_ln, cur_col, n_lines;
	logic       dirty, ins_mode;

	out_beat_t  pending_status [$];
	int         err_cnt;
	int         idle_cycles;
	bit         hold_rx;
	bit         random_rx;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic void blank_line(int ln);
		for (int c = 0; c < LINE_CHARS; c++) grid[ln][c] = CH_SP;
		len_of[ln] = 0;
	endfunction

	function automatic void copy_line(int dst, int src);
		grid[dst] = grid[src];
		len_of[dst] = len_of[src];
	endfunction

	function automatic void wipe_doc();
		for (int l = 0; l < LINES; l++) blank_line(l);
		cur_ln = 0;
		cur_col = 0;
		n_lines = 1;
	endfunction

	function automatic bit delete_char(int col);
		int n;
		n = len_of[cur_ln];
		if (col >= n) return 0;
		for (int i = col; i + 1 < n; i++) grid[cur_ln][i] = grid[cur_ln][i+1];
		grid[cur_ln][n-1] = CH_SP;
		len_of[cur_ln] = n - 1;
		if (cur_col > n - 1) cur_col = n - 1;
		dirty = 1;
		return 1;
	endfunction

	function automatic bit join_line();
		int p, pl, cl;
		if (cur_ln == 0) return 0;
		p = cur_ln - 1;
		pl = len_of[p];
		cl = len_of[cur_ln];
		if (pl + cl > LINE_CHARS) return 0;
		for (int i = 0; i < cl; i++) grid[p][pl+i] = grid[cur_ln][i];
		len_of[p] = pl + cl;
		for (int i = cur_ln; i + 1 < n_lines; i++) copy_line(i, i + 1);
		blank_line(n_lines - 1);
		n_lines--;
		cur_ln = p;
		cur_col = pl;
		dirty = 1;
		return 1;
	endfunction

	function automatic bit split_at_cursor();
		int nl, tl;
		if (n_lines >= LINES) return 0;
		nl = cur_ln + 1;
		tl = len_of[cur_ln] > cur_col ? len_of[cur_ln] - cur_col : 0;
		for (int i = n_lines; i > nl; i--) copy_line(i, i - 1);
		blank_line(nl);
		for (int i = 0; i < tl; i++) begin
			grid[nl][i] = grid[cur_ln][cur_col+i];
			grid[cur_ln][cur_col+i] = CH_SP;
		end
		len_of[nl] = tl;
		len_of[cur_ln] = cur_col;
		n_lines++;
		cur_ln = nl;
		cur_col = 0;
		dirty = 1;
		return 1;
	endfunction

	function automatic bit type_char(logic [6:0] ch);
		int n;
		n = len_of[cur_ln];
		if (ins_mode) begin
			if (n >= LINE_CHARS) return 0;
			for (int i = n; i > cur_col; i--) grid[cur_ln][i] = grid[cur_ln][i-1];
			grid[cur_ln][cur_col] = ch;
			len_of[cur_ln] = n + 1;
		end else begin
			if (cur_col >= LINE_CHARS) return 0;
			grid[cur_ln][cur_col] = ch;
			if (cur_col >= n) len_of[cur_ln] = cur_col + 1;
		end
		cur_col++;
		dirty = 1;
		return 1;
	endfunction

	function automatic bit apply_byte(logic [7:0] b);
		logic [6:0] ch;
		ch = b[6:0];
		if (ch == CH_BS) begin
			if (cur_col == 0) return join_line();
			cur_col--;
			return delete_char(cur_col);
		end
		if (ch == CH_LF) return split_at_cursor();
		if (ch == CH_DEL) return delete_char(cur_col);
		if (ch < CH_SP || ch > CH_TILDE) return 0;
		return type_char(ch);
	endfunction

	function automatic out_beat_t edit_and_report(in_beat_t cmd);
		out_beat_t r;
		bit        chg;
		int        t;
		r = '0;
		chg = 0;
		case (cmd.action)
			ACT_WRITE: chg = apply_byte(cmd.byte_in);
			ACT_LEFT: if (cur_col > 0) begin
				cur_col--;
				chg = 1;
			end
			ACT_RIGHT: if (cur_col < len_of[cur_ln]) begin
				cur_col++;
				chg = 1;
			end
			ACT_UP, ACT_DOWN: begin
				if (cmd.action == ACT_UP ? cur_ln > 0 : cur_ln + 1 < n_lines) begin
					cur_ln = cmd.action == ACT_UP ? cur_ln - 1 : cur_ln + 1;
					if (cur_col > len_of[cur_ln]) cur_col = len_of[cur_ln];
					chg = 1;
				end
			end
			ACT_CLRLN: begin
				chg = len_of[cur_ln] > 0;
				blank_line(cur_ln);
				cur_col = 0;
				if (chg) dirty = 1;
			end
			ACT_CLRALL: begin
				chg = n_lines != 1 || len_of[0] > 0;
				wipe_doc();
				if (chg) dirty = 1;
			end
			ACT_HEAD: begin
				chg = cur_ln != 0 || cur_col != 0;
				cur_ln = 0;
				cur_col = 0;
			end
			ACT_END: begin
				t = n_lines - 1;
				chg = cur_ln != t || cur_col != len_of[t];
				cur_ln = t;
				cur_col = len_of[t];
			end
			ACT_SAVED: dirty = 0;
			ACT_READ: begin
				r.read_length = 6'(len_of[cmd.read_line]);
				r.read_char = grid[cmd.read_line][cmd.read_column];
			end
			default: ;
		endcase
		r.changed = chg;
		r.cursor_line_out = 4'(cur_ln);
		r.cursor_column_out = 6'(cur_col);
		r.line_count_out = 5'(n_lines);
		r.dirty_out = dirty;
		return r;
	endfunction

	// receiver stall: random per beat, or held off for a stretch
	initial begin
		int w;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_stall <= 1;
				repeat (300) @(negedge clk);
				hold_rx = 0;
			end
			w = random_rx ? $urandom_range(0, 3) : 0;
			if (w > 0) begin
				out_stall <= 1;
				repeat (w - 1) @(negedge clk);
			end else begin
				out_stall <= 0;
			end
		end
	end

	// compare each result beat with the oldest prediction
	initial begin
		out_beat_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_status.size() == 0) begin
					$error("unexpected result beat %h", out_data);
					err_cnt++;
				end else begin
					want = pending_status.pop_front();
					if (out_data.changed !== want.changed) begin
						$error("changed: exp %0d got %0d", want.changed, out_data.changed);
						err_cnt++;
					end
					if (out_data.cursor_line_out !== want.cursor_line_out) begin
						$error("cursor_line_out: exp %0d got %0d",
							want.cursor_line_out, out_data.cursor_line_out);
						err_cnt++;
					end
					if (out_data.cursor_column_out !== want.cursor_column_out) begin
						$error("cursor_column_out: exp %0d got %0d",
							want.cursor_column_out, out_data.cursor_column_out);
						err_cnt++;
					end
					if (out_data.line_count_out !== want.line_count_out) begin
						$error("line_count_out: exp %0d got %0d",
							want.line_count_out, out_data.line_count_out);
						err_cnt++;
					end
					if (out_data.dirty_out !== want.dirty_out) begin
						$error("dirty_out: exp %0d got %0d", want.dirty_out, out_data.dirty_out);
						err_cnt++;
					end
					if (out_data.read_char !== want.read_char) begin
						$error("read_char: exp %h got %h", want.read_char, out_data.read_char);
						err_cnt++;
					end
					if (out_data.read_length !== want.read_length) begin
						$error("read_length: exp %0d got %0d",
							want.read_length, out_data.read_length);
						err_cnt++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("fixed_line_text_editor_buffer_tb: errors");
				$finish;
			end
		end
	end

	task automatic send_cmd(logic [3:0] act, logic [7:0] b = 8'h00,
			logic [3:0] rl = 4'd0, logic [4:0] rc = 5'd0);
		in_beat_t cmd;
		int w;
		w = $urandom_range(0, 3);
		repeat (w) @(negedge clk);
		cmd.action = act;
		cmd.byte_in = b;
		cmd.read_line = rl;
		cmd.read_column = rc;
		in_data = cmd;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		pending_status.push_back(edit_and_report(cmd));
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain();
		while (pending_status.size() != 0) @(posedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_mode(logic m);
		drain();
		@(negedge clk);
		wr_en <= 1;
		wr_data <= m;
		@(negedge clk);
		wr_en <= 0;
		ins_mode = m;
	endtask

	task automatic send_rand_cmd();
		int p;
		logic [7:0] b;
		p = $urandom_range(0, 99);
		if (p < 45) b = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 7'($urandom_range(32, 126))};
		else if (p < 52) b = {1'($urandom), CH_BS};
		else if (p < 57) b = {1'($urandom), CH_LF};
		else if (p < 62) b = {1'($urandom), CH_DEL};
		else if (p < 66) b = 8'($urandom);
		if (p < 66) send_cmd(ACT_WRITE, b);
		else if (p < 94) send_cmd(4'($urandom_range(1, 10)), 8'($urandom),
				4'($urandom), 5'($urandom));
		else if (p < 97) send_cmd(ACT_READ, 8'($urandom), 4'($urandom), 5'($urandom));
		else send_cmd(4'($urandom_range(11, 15)), 8'($urandom));
	endtask

	task automatic test_directed_edits();
		send_cmd(ACT_WRITE, 8'h08);               // backspace at origin
		send_cmd(ACT_WRITE, 8'h7F);               // delete at line end
		send_cmd(ACT_WRITE, 8'hC1);               // high bit dropped
		send_cmd(ACT_WRITE, 8'h7E);
		send_cmd(ACT_WRITE, 8'h20);
		send_cmd(ACT_WRITE, 8'h01);               // ignored control
		send_cmd(ACT_WRITE, 8'hFF);
		send_cmd(ACT_LEFT);
		send_cmd(ACT_RIGHT);
		send_cmd(ACT_WRITE, 8'h0A);
		send_cmd(ACT_UP);
		send_cmd(ACT_DOWN);
		send_cmd(ACT_DOWN);
		send_cmd(ACT_WRITE, 8'h08);               // join
		send_cmd(ACT_END);
		send_cmd(ACT_HEAD);
		send_cmd(ACT_READ, 8'h00, 4'd0, 5'd0);
		send_cmd(ACT_READ, 8'h00, 4'd15, 5'd31);
		send_cmd(ACT_SAVED);
		send_cmd(ACT_CLRLN);
		send_cmd(ACT_CLRLN);
		send_cmd(ACT_CLRALL);
		send_cmd(ACT_CLRALL);
		send_cmd(4'd11);
		send_cmd(4'd15, 8'hFF, 4'hF, 5'h1F);
	endtask

	task automatic test_full_grid();
		// overwrite past the edge, fill all lines, refused split, then a join
		repeat (33) send_cmd(ACT_WRITE, 8'h41);
		repeat (16) send_cmd(ACT_WRITE, 8'h0A);
		send_cmd(ACT_WRITE, 8'h42);
		send_cmd(ACT_UP);
		send_cmd(ACT_WRITE, 8'h08);
		send_cmd(ACT_CLRALL);
		send_cmd(ACT_SAVED);
	endtask

	task automatic test_insert_mode();
		set_mode(1);
		repeat (33) send_cmd(ACT_WRITE, 8'($urandom_range(32, 126)));
		send_cmd(ACT_HEAD);
		send_cmd(ACT_WRITE, 8'h0A);
		send_cmd(ACT_WRITE, 8'h08);
		send_cmd(ACT_WRITE, 8'h0A);
		send_cmd(ACT_END);
		send_cmd(ACT_WRITE, 8'h30);
		send_cmd(ACT_HEAD);
		send_cmd(ACT_DOWN);
		send_cmd(ACT_WRITE, 8'h08);               // join that exactly fills the line
	endtask

	task automatic test_random_mix(int n, logic m);
		set_mode(m);
		random_rx = 1;
		for (int i = 0; i < n; i++) send_rand_cmd();
	endtask

	task automatic test_backpressure();
		hold_rx = 1;
		for (int i = 0; i < 12; i++) send_rand_cmd();
	endtask

	initial begin
		err_cnt = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		wr_en = 0;
		wr_data = 0;
		hold_rx = 0;
		random_rx = 0;
		wipe_doc();
		dirty = 0;
		ins_mode = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		test_directed_edits();
		test_full_grid();
		test_insert_mode();
		test_random_mix(180, 0);
		test_random_mix(180, 1);
		test_backpressure();
		test_random_mix(90, 0);
		drain();
		if (err_cnt == 0) $display("fixed_line_text_editor_buffer_tb: clean");
		else $display("fixed_line_text_editor_buffer_tb: errors");
		$finish;
	end

endmodule
